/* src/bcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the balance cascade controller
// Register indexes and reset values, multiply-accumulate request format,
// fixed-point widths and guard limits.
// ----------------------------------------------------------------------------
package bcc_pkg;

   // shared multiply-accumulate unit
   localparam int ACC_W = 51;   // accumulator, holds the widest PI sum
   localparam int OPA_W = 33;   // signed operand
   localparam int OPB_W = 16;   // unsigned coefficient

   localparam logic [1:0] MAC_HOLD      = 2'd0;
   localparam logic [1:0] MAC_LOAD      = 2'd1;
   localparam logic [1:0] MAC_ADD       = 2'd2;
   localparam logic [1:0] MAC_SHIFT_ADD = 2'd3;   // acc = (acc >>> 6) + a*b

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [OPA_W-1:0] a;
      logic [OPB_W-1:0]        b;
   } mac_req_type;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN_P   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN_D   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN_P   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN_I   = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_ANGLE     = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_LIMIT    = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_POSITION_LIMIT = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SETPOINT = 8'd7;

   localparam logic [15:0] RST_ANGLE_GAIN_P   = 16'd23373;
   localparam logic [15:0] RST_ANGLE_GAIN_D   = 16'd54;
   localparam logic [15:0] RST_SPEED_GAIN_P   = 16'd1306;
   localparam logic [15:0] RST_SPEED_GAIN_I   = 16'd26;
   localparam logic [14:0] RST_ZERO_ANGLE     = 15'd0;
   localparam logic [14:0] RST_MOTOR_LIMIT    = 15'd6900;
   localparam logic [22:0] RST_POSITION_LIMIT = 23'd550000;
   localparam logic [15:0] RST_SPEED_SETPOINT = 16'd0;

   typedef struct packed {
      logic [15:0]        angle_gain_p;
      logic [15:0]        angle_gain_d;
      logic [15:0]        speed_gain_p;
      logic [15:0]        speed_gain_i;
      logic signed [14:0] zero_angle;
      logic [14:0]        motor_limit;
      logic [22:0]        position_limit;
      logic signed [15:0] speed_setpoint;
   } cfg_type;

   // low-pass weights: 179/256 old, 77/256 new (new one prescaled by 256)
   localparam logic [OPB_W-1:0] FILT_OLD    = 16'd179;
   localparam logic [OPB_W-1:0] FILT_NEW_Q8 = 16'd19712;

   // guards in 1/64 degree: 10 and 45 degrees
   localparam logic signed [15:0] PITCH_GUARD = 16'sd640;
   localparam logic signed [15:0] TILT_GUARD  = 16'sd2880;

endpackage
`default_nettype wire

/* src/bcc_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_mac: shared multiply-accumulate unit
// One signed 33 x unsigned 16 product per cycle into a registered accumulator,
// with hold, load, add and shift-then-add modes.
// ----------------------------------------------------------------------------
module bcc_mac (
   input  wire logic                              clock,
   input  wire bcc_pkg::mac_req_type              mac_req,
   output logic signed [bcc_pkg::ACC_W-1:0]       acc
);
   import bcc_pkg::*;

   logic signed [OPA_W+OPB_W:0] prod;
   logic signed [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;

   assign prod     = $signed(mac_req.a) * $signed({1'b0, mac_req.b});
   assign prod_ext = {{(ACC_W-OPA_W-OPB_W-1){prod[OPA_W+OPB_W]}}, prod};

   always_comb begin
      case (mac_req.mode)
         MAC_LOAD:      acc_in = prod_ext;
         MAC_ADD:       acc_in = acc_ff + prod_ext;
         MAC_SHIFT_ADD: acc_in = (acc_ff >>> 6) + prod_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

/* src/bcc_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_csr: configuration register file
// Gains, offsets and limits, written one word at a time; always ready.
// ----------------------------------------------------------------------------
module bcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bcc_pkg::CSR_DATA_W-1:0]   csr_data,
   output bcc_pkg::cfg_type                      cfg
);
   import bcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ANGLE_GAIN_P:   cfg_in.angle_gain_p   = csr_data[15:0];
            REG_ANGLE_GAIN_D:   cfg_in.angle_gain_d   = csr_data[15:0];
            REG_SPEED_GAIN_P:   cfg_in.speed_gain_p   = csr_data[15:0];
            REG_SPEED_GAIN_I:   cfg_in.speed_gain_i   = csr_data[15:0];
            REG_ZERO_ANGLE:     cfg_in.zero_angle     = $signed(csr_data[14:0]);
            REG_MOTOR_LIMIT:    cfg_in.motor_limit    = csr_data[14:0];
            REG_POSITION_LIMIT: cfg_in.position_limit = csr_data[22:0];
            REG_SPEED_SETPOINT: cfg_in.speed_setpoint = $signed(csr_data[15:0]);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_gain_p   <= RST_ANGLE_GAIN_P;
         cfg_ff.angle_gain_d   <= RST_ANGLE_GAIN_D;
         cfg_ff.speed_gain_p   <= RST_SPEED_GAIN_P;
         cfg_ff.speed_gain_i   <= RST_SPEED_GAIN_I;
         cfg_ff.zero_angle     <= $signed(RST_ZERO_ANGLE);
         cfg_ff.motor_limit    <= RST_MOTOR_LIMIT;
         cfg_ff.position_limit <= RST_POSITION_LIMIT;
         cfg_ff.speed_setpoint <= $signed(RST_SPEED_SETPOINT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/balance_cascade_controller_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// balance_cascade_controller_top: PD angle loop cascaded with a PI speed loop
// Takes one control-tick word, returns one pair of wheel drives and a fall flag.
// ----------------------------------------------------------------------------
// A small sequencer steps every product of the tick through one shared
// multiply-accumulate unit, at most one product per cycle. A word without
// speed_tick runs A1 to A5 and ST_OUT until req_tready is back, the result
// showing on the rsp side at that same edge; a word with speed_tick first runs
// SUM and the filter, position and PI steps. A pending result does not block
// the next word; only the final load waits when the output register is full.
// Configuration words are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module balance_cascade_controller_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // tilt_angle[14:0], pitch_angle[29:15], gyro_rate[45:30], left_count[61:46],
   // right_count[77:62], drive_speed[93:78], turn_offset[109:94],
   // ranging_offset[125:110], zero fill [127:126]
   input  wire logic [127:0] req_tdata,
   // speed_tick[0]
   input  wire logic         req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // left_magnitude[14:0], left_reverse[15], right_magnitude[30:16],
   // right_reverse[31], fallen[32], zero fill [39:33]
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import bcc_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SUM  = 5'd1;
   localparam logic [4:0] ST_F1   = 5'd2;
   localparam logic [4:0] ST_F2   = 5'd3;
   localparam logic [4:0] ST_F3   = 5'd4;
   localparam logic [4:0] ST_P1   = 5'd5;
   localparam logic [4:0] ST_P2   = 5'd6;
   localparam logic [4:0] ST_P3   = 5'd7;
   localparam logic [4:0] ST_S1   = 5'd8;
   localparam logic [4:0] ST_S2   = 5'd9;
   localparam logic [4:0] ST_S3   = 5'd10;
   localparam logic [4:0] ST_A1   = 5'd11;
   localparam logic [4:0] ST_A2   = 5'd12;
   localparam logic [4:0] ST_A3   = 5'd13;
   localparam logic [4:0] ST_A4   = 5'd14;
   localparam logic [4:0] ST_A5   = 5'd15;
   localparam logic [4:0] ST_OUT  = 5'd16;

   localparam logic signed [36:0] TRUNC_BIAS = 37'sd255;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &x[ACC_W-1:31];
      hi_zeros = ~(|x[ACC_W-1:31]);
      if (hi_ones || hi_zeros) begin
         sat32 = x[31:0];
      end else if (x[ACC_W-1]) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = 32'sh7fff_ffff;
      end
   endfunction

   cfg_type     cfg;
   mac_req_type mac_req;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_sh8;

   // request fields
   logic signed [14:0] tilt_w;
   logic signed [14:0] pitch_w;
   logic signed [15:0] gyro_w;
   logic signed [15:0] lcnt_w;
   logic signed [15:0] rcnt_w;
   logic signed [15:0] drive_w;
   logic signed [15:0] turn_w;
   logic signed [15:0] rang_w;

   logic [4:0]         state_ff, state_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [15:0] gyro_ff, gyro_in;
   logic signed [15:0] drive_ff, drive_in;
   logic signed [15:0] turn_ff, turn_in;
   logic signed [15:0] rang_ff, rang_in;
   logic signed [15:0] diff_ff, diff_in;
   logic [31:0]        left_sum_ff, left_sum_in;
   logic [31:0]        right_sum_ff, right_sum_in;
   logic signed [32:0] opnd_ff, opnd_in;
   logic signed [31:0] sf_ff, sf_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] term_ff, term_in;
   logic               fall_ff, fall_in;
   logic signed [33:0] ptmp_ff, ptmp_in;
   logic signed [36:0] lq_ff, lq_in;
   logic signed [36:0] rq_ff, rq_in;
   logic signed [28:0] lw_ff, lw_in;
   logic signed [28:0] rw_ff, rw_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [16:0] offs_sum;
   logic signed [33:0] plim;
   logic signed [33:0] pos_pick;
   logic signed [36:0] lq_bias, rq_bias;
   logic signed [28:0] mlim;
   logic signed [28:0] lc, rc;
   logic signed [28:0] lmag, rmag;
   logic               fell, lifted;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcc_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .acc     (acc)
   );

   assign tilt_w  = $signed(req_tdata[14:0]);
   assign pitch_w = $signed(req_tdata[29:15]);
   assign gyro_w  = $signed(req_tdata[45:30]);
   assign lcnt_w  = $signed(req_tdata[61:46]);
   assign rcnt_w  = $signed(req_tdata[77:62]);
   assign drive_w = $signed(req_tdata[93:78]);
   assign turn_w  = $signed(req_tdata[109:94]);
   assign rang_w  = $signed(req_tdata[125:110]);

   assign req_tready = (state_ff == ST_IDLE);
   assign acc_sh8    = acc >>> 8;

   assign offs_sum = {drive_ff[15], drive_ff} + {rang_ff[15], rang_ff};
   assign plim     = $signed({3'b000, cfg.position_limit, 8'h00});
   assign pos_pick = fall_ff ? 34'sd0 : ptmp_ff;

   // truncation toward zero of the Q8 drive sums
   assign lq_bias = lq_ff + (lq_ff[36] ? TRUNC_BIAS : 37'sd0);
   assign rq_bias = rq_ff + (rq_ff[36] ? TRUNC_BIAS : 37'sd0);

   assign mlim = $signed({14'd0, cfg.motor_limit});

   always_comb begin
      if (lw_ff > mlim) begin
         lc = mlim;
      end else if (lw_ff < -mlim) begin
         lc = -mlim;
      end else begin
         lc = lw_ff;
      end
      if (rw_ff > mlim) begin
         rc = mlim;
      end else if (rw_ff < -mlim) begin
         rc = -mlim;
      end else begin
         rc = rw_ff;
      end
   end

   assign lmag   = lc[28] ? -lc : lc;
   assign rmag   = rc[28] ? -rc : rc;
   assign fell   = (diff_ff > TILT_GUARD) || (diff_ff < -TILT_GUARD);
   assign lifted = ($signed({pitch_ff[14], pitch_ff}) > PITCH_GUARD) ||
                   ($signed({pitch_ff[14], pitch_ff}) < -PITCH_GUARD);

   always_comb begin
      state_in     = state_ff;
      pitch_in     = pitch_ff;
      gyro_in      = gyro_ff;
      drive_in     = drive_ff;
      turn_in      = turn_ff;
      rang_in      = rang_ff;
      diff_in      = diff_ff;
      left_sum_in  = left_sum_ff;
      right_sum_in = right_sum_ff;
      opnd_in      = opnd_ff;
      sf_in        = sf_ff;
      pos_in       = pos_ff;
      term_in      = term_ff;
      fall_in      = fall_ff;
      ptmp_in      = ptmp_ff;
      lq_in        = lq_ff;
      rq_in        = rq_ff;
      lw_in        = lw_ff;
      rw_in        = rw_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mac_req.mode = MAC_HOLD;
      mac_req.a    = opnd_ff;
      mac_req.b    = cfg.speed_gain_p;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pitch_in     = pitch_w;
               gyro_in      = gyro_w;
               drive_in     = drive_w;
               turn_in      = turn_w;
               rang_in      = rang_w;
               diff_in      = {tilt_w[14], tilt_w} - {cfg.zero_angle[14], cfg.zero_angle};
               left_sum_in  = left_sum_ff + {{16{lcnt_w[15]}}, lcnt_w};
               right_sum_in = right_sum_ff - {{16{rcnt_w[15]}}, rcnt_w};
               state_in     = req_tuser ? ST_SUM : ST_A1;
            end
         end
         ST_SUM: begin
            opnd_in      = $signed({left_sum_ff[31], left_sum_ff}) +
                           $signed({right_sum_ff[31], right_sum_ff});
            left_sum_in  = 32'd0;
            right_sum_in = 32'd0;
            state_in     = ST_F1;
         end
         ST_F1: begin
            mac_req.mode = MAC_LOAD;
            mac_req.a    = {sf_ff[31], sf_ff};
            mac_req.b    = FILT_OLD;
            state_in     = ST_F2;
         end
         ST_F2: begin
            mac_req.mode = MAC_ADD;
            mac_req.a    = opnd_ff;
            mac_req.b    = FILT_NEW_Q8;
            state_in     = ST_F3;
         end
         ST_F3: begin
            sf_in    = sat32(acc_sh8);
            state_in = ST_P1;
         end
         ST_P1: begin
            ptmp_in  = {{2{pos_ff[31]}}, pos_ff} + {{2{sf_ff[31]}}, sf_ff};
            state_in = ST_P2;
         end
         ST_P2: begin
            ptmp_in  = ptmp_ff + {{9{offs_sum[16]}}, offs_sum, 8'h00};
            state_in = ST_P3;
         end
         ST_P3: begin
            // fall of the previous tick zeroes the position before the clamp
            if (pos_pick > plim) begin
               pos_in = plim[31:0];
            end else if (pos_pick < -plim) begin
               pos_in = 32'(-plim);
            end else begin
               pos_in = pos_pick[31:0];
            end
            opnd_in  = {sf_ff[31], sf_ff} -
                       {{9{cfg.speed_setpoint[15]}}, cfg.speed_setpoint, 8'h00};
            state_in = ST_S1;
         end
         ST_S1: begin
            mac_req.mode = MAC_LOAD;
            mac_req.a    = opnd_ff;
            mac_req.b    = cfg.speed_gain_p;
            state_in     = ST_S2;
         end
         ST_S2: begin
            mac_req.mode = MAC_ADD;
            mac_req.a    = {pos_ff[31], pos_ff};
            mac_req.b    = cfg.speed_gain_i;
            state_in     = ST_S3;
         end
         ST_S3: begin
            term_in  = sat32(acc_sh8);
            state_in = ST_A1;
         end
         ST_A1: begin
            mac_req.mode = MAC_LOAD;
            mac_req.a    = {{17{diff_ff[15]}}, diff_ff};
            mac_req.b    = cfg.angle_gain_p;
            state_in     = ST_A2;
         end
         ST_A2: begin
            // floor(diff*kp/64) + gyro*kd
            mac_req.mode = MAC_SHIFT_ADD;
            mac_req.a    = {{17{gyro_ff[15]}}, gyro_ff};
            mac_req.b    = cfg.angle_gain_d;
            state_in     = ST_A3;
         end
         ST_A3: begin
            lq_in    = acc[36:0] + {{5{term_ff[31]}}, term_ff};
            rq_in    = acc[36:0] + {{5{term_ff[31]}}, term_ff};
            state_in = ST_A4;
         end
         ST_A4: begin
            lq_in    = lq_ff + {{13{turn_ff[15]}}, turn_ff, 8'h00};
            rq_in    = rq_ff - {{13{turn_ff[15]}}, turn_ff, 8'h00};
            state_in = ST_A5;
         end
         ST_A5: begin
            lw_in    = lq_bias[36:8];
            rw_in    = rq_bias[36:8];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in         = 40'd0;
               rsp_data_in[14:0]   = (fell || lifted) ? 15'd0 : lmag[14:0];
               rsp_data_in[15]     = lc[28];
               rsp_data_in[30:16]  = (fell || lifted) ? 15'd0 : rmag[14:0];
               rsp_data_in[31]     = rc[28];
               rsp_data_in[32]     = fell;
               fall_in             = fell;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_sum_ff  <= 32'd0;
         right_sum_ff <= 32'd0;
         sf_ff        <= 32'sd0;
         pos_ff       <= 32'sd0;
         term_ff      <= 32'sd0;
         fall_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_sum_ff  <= left_sum_in;
         right_sum_ff <= right_sum_in;
         sf_ff        <= sf_in;
         pos_ff       <= pos_in;
         term_ff      <= term_in;
         fall_ff      <= fall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff    <= pitch_in;
      gyro_ff     <= gyro_in;
      drive_ff    <= drive_in;
      turn_ff     <= turn_in;
      rang_ff     <= rang_in;
      diff_ff     <= diff_in;
      opnd_ff     <= opnd_in;
      ptmp_ff     <= ptmp_in;
      lq_ff       <= lq_in;
      rq_ff       <= rq_in;
      lw_ff       <= lw_in;
      rw_ff       <= rw_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
